/* design/fpsa_pkg.sv */
// Shared types and constants of the half-float partial-sum accumulator.
`default_nettype none

package fpsa_pkg;

    // binary16 fields
    localparam logic [4:0] EXP_MAX  = 5'h1f;
    localparam logic [4:0] EXP_BIAS = 5'd15;

    // Q.10 fixed point
    localparam int Q_FRAC_BITS = 10;
    localparam logic signed [31:0] Q_POS_INF = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_NEG_INF = 32'sh8000_0000;

    // decimal fraction and row addressing
    localparam logic [9:0] MILLIS       = 10'd1000;
    localparam int         BLOCK_STRIDE = 64;
    localparam int         BLOCK_COUNT  = 16;

    // row record widths, sized for the largest supported configuration
    localparam int SUM_W     = 38;
    localparam int IDX_MAX_W = 16;

    // depth of the queue between the front and back parts
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // one finished row: raw Q.10 sum plus where and how it lands
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [IDX_MAX_W-1:0]    idx;
        logic                    first;
        logic                    done;
    } t_row_rec;

    // queue status toward its producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

/* design/fpsa_if.sv */
// Valid/ready channel interfaces for the input elements and the result rows.
`default_nettype none

interface fpsa_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] partial_sum_half;
    logic [3:0]  row_block;
    logic        first_column_chunk;

    modport source (output valid, output partial_sum_half, output row_block,
                    output first_column_chunk, input ready);
    modport sink   (input valid, input partial_sum_half, input row_block,
                    input first_column_chunk, output ready);
endinterface

interface fpsa_out_if;
    logic               valid;
    logic               ready;
    logic [9:0]         result_row;
    logic signed [31:0] integer_total;
    logic [9:0]         fraction_millis;
    logic               block_done;

    modport source (output valid, output result_row, output integer_total,
                    output fraction_millis, output block_done, input ready);
    modport sink   (input valid, input result_row, input integer_total,
                    input fraction_millis, input block_done, output ready);
endinterface

`default_nettype wire

/* design/fp16_partial_sum_accumulator_unit.sv */
// Top level of the half-float partial-sum accumulator: front, row queue, back.
//
//   channel  | dir | transfer when        | payload
//   ---------+-----+----------------------+---------------------------------------------
//   i_in     | in  | valid && ready       | partial_sum_half, row_block, first_column_chunk
//   o_out    | out | valid && ready       | result_row, integer_total, fraction_millis,
//            |     |                      | block_done
//
// Sustained rate is one element per cycle while the output is not stalled; the row
// store's single read and single write port take one finished row per cycle. A row's
// result passes the conversion register, row queue, update stage and output register.
// Reset (synchronous, active low) clears counters, the running sum, the queue and
// all valid flags. The row store is not cleared and needs no clearing pass.
// An output stall backs up into the 4-entry row queue; i_in.ready drops only once
// that queue is full and a row-ending element is waiting.
`default_nettype none

module fp16_partial_sum_accumulator_unit #(
    parameter int ELEMENTS_PER_ROW = 16,
    parameter int ROWS_PER_BLOCK   = 64,
    parameter int RESULT_DEPTH     = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fpsa_in_if.sink   i_in,
    fpsa_out_if.source o_out
);
    import fpsa_pkg::*;

    logic     w_push;
    logic     w_pop;
    t_row_rec w_rec;
    t_row_rec w_head;
    t_q_stat  w_q_stat;

    // accept and convert elements, sum rows
    fpsa_front #(
        .ELEMENTS_PER_ROW (ELEMENTS_PER_ROW),
        .ROWS_PER_BLOCK   (ROWS_PER_BLOCK),
        .RESULT_DEPTH     (RESULT_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_rec    (w_rec)
    );

    // decouple the row producer from the store update
    fpsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // split, accumulate into the row store, emit the updated row
    fpsa_back #(
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    // never push a finished row into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("row pushed into full queue");

    // never pop an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("row popped from empty queue");

    // a queue that was full and saw no pop cannot be empty next cycle
    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.full && !w_pop) |=> !w_q_stat.empty)
        else $error("queue lost rows without a pop");

endmodule

`default_nettype wire

/* design/fpsa_front.sv */
// Front part: convert binary16 elements to Q.10, sum each row, queue finished rows.
`default_nettype none

module fpsa_front #(
    parameter int ELEMENTS_PER_ROW = 16,
    parameter int ROWS_PER_BLOCK   = 64,
    parameter int RESULT_DEPTH     = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    fpsa_in_if.sink                 i_in,
    input  wire fpsa_pkg::t_q_stat  i_q_stat,
    output logic                    o_push,
    output fpsa_pkg::t_row_rec      o_rec
);
    import fpsa_pkg::*;

    localparam int CNT_W = (ELEMENTS_PER_ROW > 1) ? $clog2(ELEMENTS_PER_ROW) : 1;
    localparam int RIB_W = (ROWS_PER_BLOCK > 1) ? $clog2(ROWS_PER_BLOCK) : 1;
    localparam int ACC_W = 32 + $clog2(ELEMENTS_PER_ROW);
    localparam int IDX_W = $clog2(RESULT_DEPTH);

    function automatic logic signed [31:0] half_to_q10(input logic [15:0] h);
        logic [4:0]         ex;
        logic [9:0]         man;
        logic [26:0]        mag;
        logic signed [31:0] res;
        ex  = h[14:10];
        man = h[9:0];
        mag = '0;
        res = '0;
        if (ex == EXP_MAX) begin
            res = (man != 10'd0) ? 32'sd0 : (h[15] ? Q_NEG_INF : Q_POS_INF);
        end else if (ex != 5'd0) begin
            if (ex >= EXP_BIAS) begin
                mag = 27'({1'b1, man}) << (ex - EXP_BIAS);
            end else begin
                mag = 27'({1'b1, man}) >> (EXP_BIAS - ex);
            end
            res = h[15] ? -$signed({5'd0, mag}) : $signed({5'd0, mag});
        end
        return res;
    endfunction

    // block base row, reduced to the store depth at elaboration
    logic [IDX_W-1:0] base_tab [BLOCK_COUNT];
    for (genvar b = 0; b < BLOCK_COUNT; b++) begin : g_base
        assign base_tab[b] = IDX_W'((b * BLOCK_STRIDE) % RESULT_DEPTH);
    end

    logic                    r_s1_valid;
    logic signed [31:0]      r_s1_q;
    logic [3:0]              r_s1_blk;
    logic                    r_s1_first;
    logic [CNT_W-1:0]        r_cnt;
    logic [RIB_W-1:0]        r_row;
    logic signed [ACC_W-1:0] r_sum;

    logic                    s1_last;
    logic                    s1_take;
    logic                    row_last;
    logic signed [ACC_W-1:0] n_sum;
    logic [IDX_W:0]          idx_raw;
    logic [IDX_W-1:0]        idx;

    assign s1_last  = (r_cnt == CNT_W'(ELEMENTS_PER_ROW - 1));
    assign s1_take  = r_s1_valid && (!s1_last || !i_q_stat.full);
    assign row_last = (r_row == RIB_W'(ROWS_PER_BLOCK - 1));
    assign n_sum    = r_sum + ACC_W'(r_s1_q);

    assign idx_raw = {1'b0, base_tab[r_s1_blk]} + (IDX_W + 1)'(r_row);
    assign idx     = (idx_raw >= (IDX_W + 1)'(RESULT_DEPTH))
                   ? IDX_W'(idx_raw - (IDX_W + 1)'(RESULT_DEPTH))
                   : IDX_W'(idx_raw);

    assign i_in.ready = !r_s1_valid || s1_take;

    assign o_push      = s1_take && s1_last;
    assign o_rec.sum   = SUM_W'(n_sum);
    assign o_rec.idx   = IDX_MAX_W'(idx);
    assign o_rec.first = r_s1_first;
    assign o_rec.done  = row_last;

    // conversion stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_q     <= half_to_q10(i_in.partial_sum_half);
            r_s1_blk   <= i_in.row_block;
            r_s1_first <= i_in.first_column_chunk;
        end
    end

    // row accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_row <= '0;
            r_sum <= '0;
        end else if (s1_take) begin
            if (s1_last) begin
                r_cnt <= '0;
                r_sum <= '0;
                r_row <= row_last ? '0 : r_row + 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
                r_sum <= n_sum;
            end
        end
    end

endmodule

`default_nettype wire

/* design/fpsa_queue.sv */
// Short queue of finished row records between the front and back parts.
`default_nettype none

module fpsa_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire fpsa_pkg::t_row_rec  i_rec,
    input  wire logic                i_pop,
    output fpsa_pkg::t_row_rec       o_head,
    output fpsa_pkg::t_q_stat        o_stat
);
    import fpsa_pkg::*;

    t_row_rec          r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_head       = r_buf[r_rd_ptr];
    assign o_stat.full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/fpsa_back.sv */
// Back part: split row sums, read-modify-write the row store, register results.
`default_nettype none

module fpsa_back #(
    parameter int RESULT_DEPTH = 1024
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fpsa_pkg::t_row_rec  i_head,
    input  wire fpsa_pkg::t_q_stat   i_q_stat,
    output logic                     o_pop,
    fpsa_out_if.source               o_out
);
    import fpsa_pkg::*;

    localparam int IDX_W = $clog2(RESULT_DEPTH);
    localparam int ENT_W = 32 + 10;

    // row store: integer part above, millis fraction below
    logic [ENT_W-1:0] r_mem [RESULT_DEPTH];

    // split of the queue head
    logic signed [SUM_W-1:0] head_fl;
    logic [31:0]             head_ipart;
    logic [9:0]              head_lo;
    logic [9:0]              head_abs;
    logic [19:0]             head_prod;

    assign head_fl    = i_head.sum >>> Q_FRAC_BITS;
    assign head_ipart = 32'(head_fl);
    assign head_lo    = i_head.sum[Q_FRAC_BITS-1:0];
    assign head_abs   = i_head.sum[SUM_W-1] ? (10'd0 - head_lo) : head_lo;
    assign head_prod  = 20'(head_abs) * 20'(MILLIS);

    // update stage
    logic             r_b_valid;
    logic [IDX_W-1:0] r_b_idx;
    logic [31:0]      r_b_ipart;
    logic [9:0]       r_b_fpart;
    logic             r_b_first;
    logic             r_b_done;
    logic [ENT_W-1:0] r_rd;

    // last write, forwarded when the store read raced it
    logic             r_lw_valid;
    logic [IDX_W-1:0] r_lw_idx;
    logic [ENT_W-1:0] r_lw_data;

    // output register
    logic               r_o_valid;
    logic [9:0]         r_o_row;
    logic signed [31:0] r_o_int;
    logic [9:0]         r_o_frac;
    logic               r_o_done;

    logic             b_retire;
    logic             b_adv;
    logic [ENT_W-1:0] old_ent;
    logic [10:0]      frac_sum;
    logic             frac_carry;
    logic [9:0]       n_frac;
    logic [31:0]      n_int;
    logic [ENT_W-1:0] n_ent;

    assign b_retire = r_b_valid && (!r_o_valid || o_out.ready);
    assign b_adv    = !r_b_valid || b_retire;
    assign o_pop    = b_adv && !i_q_stat.empty;

    assign old_ent    = (r_lw_valid && (r_lw_idx == r_b_idx)) ? r_lw_data : r_rd;
    assign frac_sum   = {1'b0, old_ent[9:0]} + {1'b0, r_b_fpart};
    assign frac_carry = (frac_sum >= {1'b0, MILLIS});

    always_comb begin
        if (r_b_first) begin
            n_int  = r_b_ipart;
            n_frac = r_b_fpart;
        end else begin
            n_int  = old_ent[ENT_W-1:10] + r_b_ipart + 32'(frac_carry);
            n_frac = frac_carry ? 10'(frac_sum - {1'b0, MILLIS}) : frac_sum[9:0];
        end
    end
    assign n_ent = {n_int, n_frac};

    // store port: read on pop, write on retire
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= r_mem[IDX_W'(i_head.idx)];
        end
        if (b_retire) begin
            r_mem[r_b_idx] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_lw_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (b_adv) begin
                r_b_valid <= o_pop;
            end
            if (b_retire) begin
                r_lw_valid <= 1'b1;
                r_o_valid  <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_idx   <= IDX_W'(i_head.idx);
            r_b_ipart <= head_ipart;
            r_b_fpart <= head_prod[19:10];
            r_b_first <= i_head.first;
            r_b_done  <= i_head.done;
        end
        if (b_retire) begin
            r_lw_idx  <= r_b_idx;
            r_lw_data <= n_ent;
            r_o_row   <= 10'(r_b_idx);
            r_o_int   <= $signed(n_int);
            r_o_frac  <= n_frac;
            r_o_done  <= r_b_done;
        end
    end

    assign o_out.valid           = r_o_valid;
    assign o_out.result_row      = r_o_row;
    assign o_out.integer_total   = r_o_int;
    assign o_out.fraction_millis = r_o_frac;
    assign o_out.block_done      = r_o_done;

endmodule

`default_nettype wire
